// File: design/orq_pkg.sv
// shared types and constants for the ordered request queue
// entry layout, ring control word between the controller and the cell chain
// no dependencies
`default_nettype none

package orq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int FLOOR_BITS  = 4;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [FLOOR_BITS-1:0] floor;
        logic [1:0]            direction;
        logic                  off;
    } entry_t;

    // what every cell of the chain does in a cycle
    typedef enum logic [1:0] {
        RING_HOLD,
        RING_ROTATE,
        RING_DROP,
        RING_LOAD
    } ring_op_t;

    typedef struct packed {
        ring_op_t         op;
        logic [CNT_W-1:0] cur;
        entry_t           load;
    } ring_ctrl_t;

endpackage

`default_nettype wire

// File: design/ordered_request_queue_wildcard_match.sv
// Ordered request queue with masked match. Entries sit in a chain of cells, oldest in
// cell 0. Add, clear, a command flagged as an error and an unused code go from the
// accepted beat through the execute and report states to the result beat; remove at
// position, remove floor, query and find first off on a non-empty queue also scan,
// one step per live entry, as the entries rotate one cell per cycle past cell 0, where
// they are tested and kept or dropped. One command is in work at a time; a new beat is
// taken while the previous result waits on the master side. Reset clears no cell.
// depends on orq_pkg, orq_ctrl, orq_cell
`default_nettype none

module ordered_request_queue_wildcard_match (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // req_floor[3:0], floor_wild[4], req_direction[6:5], direction_wild[7],
    // req_off[8], off_wild[9], position[13:10], zero[15:14]
    input  wire logic [15:0] s_tdata,
    // cmd[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // match[0], found[1], hit_floor[5:2], hit_direction[7:6], fill[12:8],
    // error[13], zero[15:14]
    output logic [15:0]      m_tdata
);

    localparam int DEPTH = orq_pkg::QUEUE_DEPTH;
    localparam int IW    = orq_pkg::IDX_W;

    orq_pkg::ring_ctrl_t ring;
    orq_pkg::entry_t     cell_data [DEPTH];

    orq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .head     (cell_data[0]),
        .ring     (ring)
    );

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == DEPTH - 1)
        begin : g_last
            // the last cell never takes its neighbor
            orq_cell u_cell (
                .clk  (clk),
                .idx  (IW'(g)),
                .ctrl (ring),
                .nbr  (cell_data[0]),
                .head (cell_data[0]),
                .data (cell_data[g])
            );
        end
        else
        begin : g_mid
            orq_cell u_cell (
                .clk  (clk),
                .idx  (IW'(g)),
                .ctrl (ring),
                .nbr  (cell_data[g+1]),
                .head (cell_data[0]),
                .data (cell_data[g])
            );
        end
    end

endmodule

`default_nettype wire

// File: design/orq_cell.sv
// one storage cell of the queue chain
// takes its neighbor, the head entry or a new entry as the ring control word says
// depends on orq_pkg
`default_nettype none

module orq_cell (
    input  wire logic                      clk,
    input  wire logic [orq_pkg::IDX_W-1:0] idx,
    input  wire orq_pkg::ring_ctrl_t       ctrl,
    input  wire orq_pkg::entry_t           nbr,
    input  wire orq_pkg::entry_t           head,
    output orq_pkg::entry_t                data
);

    localparam int CW = orq_pkg::CNT_W;

    orq_pkg::entry_t data_reg;
    orq_pkg::entry_t data_next;
    logic [CW-1:0]   idx_c;
    logic [CW-1:0]   idx_p1;

    assign idx_c  = CW'(idx);
    assign idx_p1 = idx_c + CW'(1);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            orq_pkg::RING_LOAD:
            begin
                if (idx_c == ctrl.cur)
                    data_next = ctrl.load;
            end
            orq_pkg::RING_ROTATE:
            begin
                // live region shifts toward the head, the old head wraps to the tail
                if (idx_p1 < ctrl.cur)
                    data_next = nbr;
                else if (idx_p1 == ctrl.cur)
                    data_next = head;
            end
            orq_pkg::RING_DROP:
            begin
                // head leaves, the old tail slot keeps its stale copy
                if (idx_p1 < ctrl.cur)
                    data_next = nbr;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: design/orq_ctrl.sv
// command sequencer of the ordered request queue
// stream handshakes, entry count, scan over the cell chain and the result register
// depends on orq_pkg
`default_nettype none

module orq_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata,
    input  wire orq_pkg::entry_t head,
    output orq_pkg::ring_ctrl_t ring
);

    localparam int CW = orq_pkg::CNT_W;
    localparam int FB = orq_pkg::FLOOR_BITS;

    typedef enum logic [2:0] {
        CMD_ADD          = 3'd0,
        CMD_REMOVE_POS   = 3'd1,
        CMD_REMOVE_FLOOR = 3'd2,
        CMD_CLEAR        = 3'd3,
        CMD_QUERY        = 3'd4,
        CMD_FIND_OFF     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_REPORT
    } state_t;

    state_t          state_reg,    state_next;
    cmd_t            cmd_reg,      cmd_next;
    logic [FB-1:0]   floor_reg,    floor_next;
    logic            fw_reg,       fw_next;
    logic [1:0]      dir_reg,      dir_next;
    logic            dw_reg,       dw_next;
    logic            off_reg,      off_next;
    logic            ow_reg,       ow_next;
    logic [3:0]      pos_reg,      pos_next;
    logic [CW-1:0]   count_reg,    count_next;
    logic [CW-1:0]   step_reg,     step_next;
    logic [CW-1:0]   total_reg,    total_next;
    logic            match_reg,    match_next;
    logic            found_reg,    found_next;
    logic            error_reg,    error_next;
    orq_pkg::entry_t hit_reg,      hit_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [15:0]     m_tdata_reg,  m_tdata_next;

    logic            head_match;
    logic            drop;
    logic [CW-1:0]   step_p1;

    assign head_match = (fw_reg || head.floor == floor_reg) &&
                        (dw_reg || head.direction == dir_reg) &&
                        (ow_reg || head.off == off_reg);
    assign step_p1    = step_reg + CW'(1);
    assign drop       = ((cmd_reg == CMD_REMOVE_POS) && (32'(step_reg) == 32'(pos_reg))) ||
                        ((cmd_reg == CMD_REMOVE_FLOOR) && (head.floor == floor_reg));

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        floor_next    = floor_reg;
        fw_next       = fw_reg;
        dir_next      = dir_reg;
        dw_next       = dw_reg;
        off_next      = off_reg;
        ow_next       = ow_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        total_next    = total_reg;
        match_next    = match_reg;
        found_next    = found_reg;
        error_next    = error_reg;
        hit_next      = hit_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        ring.op        = orq_pkg::RING_HOLD;
        ring.cur       = count_reg;
        ring.load      = '{floor: floor_reg, direction: dir_reg, off: off_reg};

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = cmd_t'(s_tuser);
                    floor_next = FB'(s_tdata[3:0]);
                    fw_next    = s_tdata[4];
                    dir_next   = s_tdata[6:5];
                    dw_next    = s_tdata[7];
                    off_next   = s_tdata[8];
                    ow_next    = s_tdata[9];
                    pos_next   = s_tdata[13:10];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                match_next = 1'b0;
                found_next = 1'b0;
                error_next = 1'b0;
                hit_next   = '0;
                step_next  = '0;
                total_next = count_reg;
                state_next = ST_REPORT;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (count_reg == CW'(orq_pkg::QUEUE_DEPTH))
                            error_next = 1'b1;
                        else
                        begin
                            ring.op    = orq_pkg::RING_LOAD;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_REMOVE_POS:
                    begin
                        if (32'(pos_reg) >= 32'(count_reg))
                            error_next = 1'b1;
                        else
                            state_next = ST_SCAN;
                    end
                    CMD_REMOVE_FLOOR, CMD_QUERY:
                    begin
                        if (count_reg != '0)
                            state_next = ST_SCAN;
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    CMD_FIND_OFF:
                    begin
                        // slot 0 as stored is the answer when nothing has off set
                        hit_next = head;
                        if (count_reg != '0)
                            state_next = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_REPORT;
                    end
                endcase
            end
            ST_SCAN:
            begin
                // every original entry passes the head once, kept ones wrap to the tail
                if (drop)
                begin
                    ring.op    = orq_pkg::RING_DROP;
                    count_next = count_reg - CW'(1);
                end
                else
                    ring.op = orq_pkg::RING_ROTATE;
                if ((cmd_reg == CMD_QUERY) && head_match)
                    match_next = 1'b1;
                if ((cmd_reg == CMD_FIND_OFF) && head.off && !found_reg)
                begin
                    found_next = 1'b1;
                    hit_next   = head;
                end
                step_next = step_p1;
                if (step_p1 == total_reg)
                    state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, error_reg, 5'(count_reg), hit_reg.direction,
                                     4'(hit_reg.floor), found_reg, match_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            step_reg     <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            step_reg     <= step_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        floor_reg   <= floor_next;
        fw_reg      <= fw_next;
        dir_reg     <= dir_next;
        dw_reg      <= dw_next;
        off_reg     <= off_next;
        ow_reg      <= ow_next;
        pos_reg     <= pos_next;
        match_reg   <= match_next;
        found_reg   <= found_next;
        error_reg   <= error_next;
        hit_reg     <= hit_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: design/orq_checker.sv
// port-level checks for the ordered request queue, bound to the top level
// depends on orq_pkg and the ports of ordered_request_queue_wildcard_match
`default_nettype none

module orq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

    // one command at a time: busy right after a beat is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a command is in work");

    // fill never goes past the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[12:8]) <= orq_pkg::QUEUE_DEPTH)
    else $error("fill above queue depth");

    // an error result carries no match or found
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> !m_tdata[0] && !m_tdata[1])
    else $error("error beat with match or found set");

    // query and find first off are different commands
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("match and found both set");

endmodule

bind ordered_request_queue_wildcard_match orq_checker u_checker (.*);

`default_nettype wire
